>>> rtl/tgbp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgbp_pkg
// Shared constants for the tagged geometric-history branch predictor.
// ----------------------------------------------------------------------------
package tgbp_pkg;

  localparam int BASE_ENTRIES_DEF   = 8192;
  localparam int LINE_ENTRIES_DEF   = 1024;
  localparam int NUM_TABLES_DEF     = 7;
  localparam int TAG_BITS_DEF       = 11;
  localparam int PRED_BITS_DEF      = 3;

  localparam int ADDR_W  = 32;
  localparam int DRAW_W  = 7;
  localparam int HIST_W  = 64;
  localparam int USE_W   = 2;
  localparam int BASE_W  = 2;

  localparam logic [DRAW_W-1:0] SECOND_PICK_RESET = 7'd33;
  localparam logic [BASE_W-1:0] BASE_RESET        = 2'd1;

  // Geometric series of history lengths.
  localparam int LEN_STEPS = 12;
  localparam int HIST_LEN [LEN_STEPS] = '{3, 5, 8, 12, 17, 24, 33, 45, 61, 82, 108, 128};

  localparam int QUEUE_DEPTH = 2;

endpackage

>>> rtl/tgbp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgbp_if
// Valid/ready channels for branch words and prediction words.
// ----------------------------------------------------------------------------
interface tgbp_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] branch_address;
  logic        outcome_taken;
  logic [6:0]  random_draw;
  modport source (output valid, branch_address, outcome_taken, random_draw, input ready);
  modport sink   (input valid, branch_address, outcome_taken, random_draw, output ready);
endinterface

interface tgbp_out_if;
  logic valid;
  logic ready;
  logic predicted_taken;
  modport source (output valid, predicted_taken, input ready);
  modport sink   (input valid, predicted_taken, output ready);
endinterface

>>> rtl/tgbp_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgbp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tgbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/tgbp_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgbp_queue
// Short register FIFO between the classifying front and the table back end.
// ----------------------------------------------------------------------------
module tgbp_queue import tgbp_pkg::*; #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] head,
  output logic             empty,
  output logic             full
);

  localparam int PW = $clog2(QUEUE_DEPTH);

  logic [WIDTH-1:0] ent_r [QUEUE_DEPTH];
  logic [PW-1:0]    wp_r, wp_nxt, rp_r, rp_nxt;
  logic [PW:0]      cnt_r, cnt_nxt;

  assign empty = (cnt_r == '0);
  assign full  = (cnt_r == (PW+1)'(QUEUE_DEPTH));
  assign head  = ent_r[rp_r];

  always_comb begin
    wp_nxt  = push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = pop  ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r + (PW+1)'(push) - (PW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) begin
      ent_r[wp_r] <= push_data;
    end
  end

endmodule

>>> rtl/tgbp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgbp_front
// Accepts branch words, folds the global history per table and forms the
// table indexes and tags of each word.
// ----------------------------------------------------------------------------
module tgbp_front import tgbp_pkg::*; #(
  parameter int BASE_ENTRIES   = BASE_ENTRIES_DEF,
  parameter int LINE_ENTRIES   = LINE_ENTRIES_DEF,
  parameter int NUM_TABLES     = NUM_TABLES_DEF,
  parameter int TAG_BITS       = TAG_BITS_DEF,
  parameter int QW             = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  tgbp_in_if.sink       in_ch,
  input  logic          clear_done,
  input  logic          q_full,
  output logic          q_push,
  output logic [QW-1:0] q_data
);

  localparam int BIDX_W = $clog2(BASE_ENTRIES);
  localparam int TIDX_W = $clog2(LINE_ENTRIES);
  localparam int LW     = TIDX_W + TAG_BITS;
  localparam int TOFS   = 1 + DRAW_W + BIDX_W;

  logic [HIST_W-1:0] hist_lo_r, hist_lo_nxt, hist_hi_r, hist_hi_nxt;

  assign in_ch.ready = clear_done && !q_full;
  assign q_push      = in_ch.valid && in_ch.ready;

  assign q_data[0]                = in_ch.outcome_taken;
  assign q_data[DRAW_W:1]         = in_ch.random_draw;
  assign q_data[TOFS-1:1+DRAW_W]  = in_ch.branch_address[BIDX_W-1:0];

  for (genvar t = 0; t < NUM_TABLES; t++) begin : g_tbl
    localparam int KR = t * (LEN_STEPS - 1) / (NUM_TABLES - 1);
    localparam int K  = (KR > LEN_STEPS - 1) ? LEN_STEPS - 1 : KR;
    localparam int L  = HIST_LEN[K];
    localparam logic [HIST_W-1:0] LO_M = (L >= 64) ? '1 : ((64'(1) << L) - 64'(1));
    localparam logic [HIST_W-1:0] HI_M = (L <= 64) ? '0 :
                                         (L >= 128) ? '1 : ((64'(1) << (L - 64)) - 64'(1));
    logic [HIST_W-1:0] fold;
    assign fold = {32'b0, in_ch.branch_address} ^ (hist_lo_r & LO_M) ^ (hist_hi_r & HI_M);
    assign q_data[TOFS + t*LW +: LW] = {fold[TAG_BITS-1:0], fold[TIDX_W-1:0]};
  end

  always_comb begin
    hist_lo_nxt = hist_lo_r;
    hist_hi_nxt = hist_hi_r;
    if (q_push) begin
      hist_hi_nxt = {hist_hi_r[HIST_W-2:0], hist_lo_r[HIST_W-1]};
      hist_lo_nxt = {hist_lo_r[HIST_W-2:0], in_ch.outcome_taken};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_lo_r <= '0;
      hist_hi_r <= '0;
    end else begin
      hist_lo_r <= hist_lo_nxt;
      hist_hi_r <= hist_hi_nxt;
    end
  end

endmodule

>>> rtl/tgbp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgbp_back
// Reads the base and tagged tables for one queued word, predicts, trains
// and allocates, and presents the prediction in an output register.
// ----------------------------------------------------------------------------
module tgbp_back import tgbp_pkg::*; #(
  parameter int BASE_ENTRIES   = BASE_ENTRIES_DEF,
  parameter int LINE_ENTRIES   = LINE_ENTRIES_DEF,
  parameter int NUM_TABLES     = NUM_TABLES_DEF,
  parameter int TAG_BITS       = TAG_BITS_DEF,
  parameter int PRED_BITS      = PRED_BITS_DEF,
  parameter int QW             = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [DRAW_W-1:0] cfg_wdata,
  input  logic              q_empty,
  input  logic [QW-1:0]     q_head,
  output logic              q_pop,
  output logic              clear_done,
  tgbp_out_if.source        out_ch
);

  localparam int BIDX_W = $clog2(BASE_ENTRIES);
  localparam int TIDX_W = $clog2(LINE_ENTRIES);
  localparam int LW     = TIDX_W + TAG_BITS;
  localparam int TOFS   = 1 + DRAW_W + BIDX_W;
  localparam int LINE_W = TAG_BITS + PRED_BITS + USE_W;
  localparam int TB     = $clog2(NUM_TABLES);
  localparam int CLR_N  = (BASE_ENTRIES > LINE_ENTRIES) ? BASE_ENTRIES : LINE_ENTRIES;
  localparam int CLR_W  = $clog2(CLR_N);
  localparam logic [PRED_BITS-1:0] PRED_HALF = PRED_BITS'(1) << (PRED_BITS - 1);
  localparam logic [PRED_BITS-1:0] PRED_MAX  = '1;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_UPD   = 2'd2;

  logic [1:0]        st_r, st_nxt;
  logic [CLR_W-1:0]  clr_r, clr_nxt;
  logic [QW-1:0]     ent_r;
  logic [DRAW_W-1:0] pick_pct_r;
  logic              ov_r, ov_nxt, op_r, op_nxt;
  logic              issue, upd, clr;

  logic [BASE_W-1:0] base_rd, base_new, base_wd;
  logic [BIDX_W-1:0] base_wa;
  logic              base_we;

  logic [LINE_W-1:0]    t_rd   [NUM_TABLES];
  logic [LINE_W-1:0]    t_wd   [NUM_TABLES];
  logic [TIDX_W-1:0]    t_wa   [NUM_TABLES];
  logic                 t_we   [NUM_TABLES];
  logic [TAG_BITS-1:0]  e_tag  [NUM_TABLES];
  logic [TIDX_W-1:0]    e_idx  [NUM_TABLES];
  logic [TAG_BITS-1:0]  r_tag  [NUM_TABLES];
  logic [PRED_BITS-1:0] r_ctr  [NUM_TABLES];
  logic [USE_W-1:0]     r_use  [NUM_TABLES];
  logic [TAG_BITS-1:0]  n_tag  [NUM_TABLES];
  logic [PRED_BITS-1:0] n_ctr  [NUM_TABLES];
  logic [USE_W-1:0]     n_use  [NUM_TABLES];

  logic              taken;
  logic [DRAW_W-1:0] draw;
  logic              best, alt, pfound, ffound, sfound, mispred;
  logic [TB-1:0]     pidx, fidx, sidx, pick;

  assign clr        = (st_r == ST_CLEAR);
  assign upd        = (st_r == ST_UPD);
  assign issue      = (st_r == ST_IDLE) && !q_empty && (!ov_r || out_ch.ready);
  assign q_pop      = issue;
  assign clear_done = !clr;
  assign taken      = ent_r[0];
  assign draw       = ent_r[DRAW_W:1];

  assign out_ch.valid           = ov_r;
  assign out_ch.predicted_taken = op_r;

  // Base table.
  assign base_we = (clr && ({1'b0, clr_r} < (CLR_W+1)'(BASE_ENTRIES))) || upd;
  assign base_wa = clr ? clr_r[BIDX_W-1:0] : ent_r[TOFS-1:1+DRAW_W];
  assign base_wd = clr ? BASE_RESET : base_new;

  tgbp_ram #(.WIDTH(BASE_W), .DEPTH(BASE_ENTRIES)) u_base (
    .clk   (clk),
    .we    (base_we),
    .waddr (base_wa),
    .wdata (base_wd),
    .raddr (q_head[TOFS-1:1+DRAW_W]),
    .rdata (base_rd)
  );

  for (genvar t = 0; t < NUM_TABLES; t++) begin : g_tbl
    assign e_idx[t] = ent_r[TOFS + t*LW +: TIDX_W];
    assign e_tag[t] = ent_r[TOFS + t*LW + TIDX_W +: TAG_BITS];
    assign r_tag[t] = t_rd[t][LINE_W-1 -: TAG_BITS];
    assign r_ctr[t] = t_rd[t][USE_W +: PRED_BITS];
    assign r_use[t] = t_rd[t][USE_W-1:0];
    assign t_we[t]  = (clr && ({1'b0, clr_r} < (CLR_W+1)'(LINE_ENTRIES))) || upd;
    assign t_wa[t]  = clr ? clr_r[TIDX_W-1:0] : e_idx[t];
    assign t_wd[t]  = clr ? '0 : {n_tag[t], n_ctr[t], n_use[t]};

    tgbp_ram #(.WIDTH(LINE_W), .DEPTH(LINE_ENTRIES)) u_line (
      .clk   (clk),
      .we    (t_we[t]),
      .waddr (t_wa[t]),
      .wdata (t_wd[t]),
      .raddr (q_head[TOFS + t*LW +: TIDX_W]),
      .rdata (t_rd[t])
    );
  end

  // Prediction, training and allocation on the read data.
  always_comb begin
    best   = (base_rd >= 2'd2);
    alt    = 1'b0;
    pfound = 1'b0;
    pidx   = '0;
    for (int t = 0; t < NUM_TABLES; t++) begin
      if (r_tag[t] == e_tag[t]) begin
        alt    = best;
        best   = (r_ctr[t] >= PRED_HALF);
        pfound = 1'b1;
        pidx   = TB'(t);
      end
    end
    mispred = (best != taken);

    ffound = 1'b0;
    sfound = 1'b0;
    fidx   = '0;
    sidx   = '0;
    for (int t = 0; t < NUM_TABLES; t++) begin
      if ((!pfound || TB'(t) > pidx) && r_use[t] == '0) begin
        if (!ffound) begin
          ffound = 1'b1;
          fidx   = TB'(t);
        end else if (!sfound) begin
          sfound = 1'b1;
          sidx   = TB'(t);
        end
      end
    end
    pick = (sfound && draw < pick_pct_r) ? sidx : fidx;

    base_new = base_rd;
    if (taken && base_rd != 2'd3) begin
      base_new = base_rd + 2'd1;
    end else if (!taken && base_rd != 2'd0) begin
      base_new = base_rd - 2'd1;
    end

    for (int t = 0; t < NUM_TABLES; t++) begin
      n_tag[t] = r_tag[t];
      n_ctr[t] = r_ctr[t];
      n_use[t] = r_use[t];
      if (pfound && pidx == TB'(t)) begin
        if (alt != best) begin
          if (best == taken && r_use[t] != 2'd3) begin
            n_use[t] = r_use[t] + 2'd1;
          end else if (best != taken && r_use[t] != 2'd0) begin
            n_use[t] = r_use[t] - 2'd1;
          end
        end
        if (taken && r_ctr[t] != PRED_MAX) begin
          n_ctr[t] = r_ctr[t] + PRED_BITS'(1);
        end else if (!taken && r_ctr[t] != '0) begin
          n_ctr[t] = r_ctr[t] - PRED_BITS'(1);
        end
      end
      if (mispred && ffound && pick == TB'(t)) begin
        n_tag[t] = e_tag[t];
        n_use[t] = '0;
        n_ctr[t] = taken ? PRED_HALF : PRED_HALF - PRED_BITS'(1);
      end
      if (mispred && !ffound && (!pfound || TB'(t) > pidx) && r_use[t] != '0) begin
        n_use[t] = r_use[t] - 2'd1;
      end
    end
  end

  always_comb begin
    st_nxt  = st_r;
    clr_nxt = clr_r;
    ov_nxt  = (ov_r && out_ch.ready) ? 1'b0 : ov_r;
    op_nxt  = op_r;
    case (st_r)
      ST_CLEAR: begin
        clr_nxt = clr_r + 1'b1;
        if (clr_r == CLR_W'(CLR_N - 1)) begin
          st_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (issue) begin
          st_nxt = ST_UPD;
        end
      end
      ST_UPD: begin
        ov_nxt = 1'b1;
        op_nxt = best;
        st_nxt = ST_IDLE;
      end
      default: st_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= ST_CLEAR;
      clr_r      <= '0;
      ov_r       <= 1'b0;
      pick_pct_r <= SECOND_PICK_RESET;
    end else begin
      st_r  <= st_nxt;
      clr_r <= clr_nxt;
      ov_r  <= ov_nxt;
      if (cfg_we) begin
        pick_pct_r <= cfg_wdata;
      end
    end
    op_r <= op_nxt;
    if (issue) begin
      ent_r <= q_head;
    end
  end

endmodule

>>> rtl/tagged_geometric_branch_predictor_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tagged_geometric_branch_predictor_top
// TAGE-style branch direction predictor with a bimodal base table and
// tagged tables indexed by geometrically longer global histories.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one resolved branch per word: its address, its real
//   direction and a random draw. out_ch returns one word per input word,
//   in order, holding the prediction made before that branch trained the
//   tables. cfg_we/cfg_wdata set the percentage under which an allocation
//   takes the second free longer table; write it only while idle.
//   The front folds the history and forms indexes and tags in the accept
//   cycle; the word then waits in a two-entry queue. The back end takes one
//   word at a time: it reads the tables, then predicts, trains, allocates,
//   writes back and loads the prediction into the output register. Because
//   of the read-modify-write of each table bank, it takes no new word before
//   the last one is written back.
//   After reset the back end sweeps all tables, one entry per cycle, over
//   max(BASE_ENTRIES, LINE_ENTRIES) entries (8192 by default); in_ch.ready
//   stays low during this sweep. A stalled out_ch holds its word; the back
//   end then waits, the queue fills and in_ch.ready drops.
// ----------------------------------------------------------------------------
module tagged_geometric_branch_predictor_top import tgbp_pkg::*; #(
  parameter int BASE_ENTRIES   = BASE_ENTRIES_DEF,
  parameter int LINE_ENTRIES   = LINE_ENTRIES_DEF,
  parameter int NUM_TABLES     = NUM_TABLES_DEF,
  parameter int TAG_BITS       = TAG_BITS_DEF,
  parameter int PRED_BITS      = PRED_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [DRAW_W-1:0] cfg_wdata,
  tgbp_in_if.sink           in_ch,
  tgbp_out_if.source        out_ch
);

  // Queue word: taken, draw, base index, then index and tag per table.
  localparam int QW = 1 + DRAW_W + $clog2(BASE_ENTRIES)
                    + NUM_TABLES * ($clog2(LINE_ENTRIES) + TAG_BITS);

  logic          q_push, q_pop, q_empty, q_full, clear_done;
  logic [QW-1:0] q_data, q_head;

  tgbp_front #(
    .BASE_ENTRIES   (BASE_ENTRIES),
    .LINE_ENTRIES   (LINE_ENTRIES),
    .NUM_TABLES     (NUM_TABLES),
    .TAG_BITS       (TAG_BITS),
    .QW             (QW)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .clear_done (clear_done),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_data     (q_data)
  );

  tgbp_queue #(.WIDTH(QW)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_data),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty),
    .full      (q_full)
  );

  tgbp_back #(
    .BASE_ENTRIES   (BASE_ENTRIES),
    .LINE_ENTRIES   (LINE_ENTRIES),
    .NUM_TABLES     (NUM_TABLES),
    .TAG_BITS       (TAG_BITS),
    .PRED_BITS      (PRED_BITS),
    .QW             (QW)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .q_empty    (q_empty),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .clear_done (clear_done),
    .out_ch     (out_ch)
  );

endmodule

>>> tb/tb_tagged_geometric_branch_predictor_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tagged_geometric_branch_predictor_top
// Self-checking bench for the tagged geometric-history branch predictor.
// Branch words go in over a valid/ready channel. A shadow copy of the base
// table, the tagged lines and the global history predicts each prediction
// word, and every returned word is checked against it in order.
// ----------------------------------------------------------------------------
module tb_tagged_geometric_branch_predictor_top;
  import tgbp_pkg::*;

  localparam int NT         = NUM_TABLES_DEF;
  localparam int TE         = LINE_ENTRIES_DEF;
  localparam int BE         = BASE_ENTRIES_DEF;
  localparam int TB         = TAG_BITS_DEF;
  localparam int PB         = PRED_BITS_DEF;
  localparam int CTR_MAX    = (1 << PB) - 1;
  localparam int CTR_HALF   = 1 << (PB - 1);
  localparam int POOL_SIZE  = 12;
  localparam int CYCLE_CAP  = 600000;
  localparam int DRAIN_GAP  = 8;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [DRAW_W-1:0] cfg_wdata;

  tgbp_in_if  branch_if ();
  tgbp_out_if pred_if ();

  tagged_geometric_branch_predictor_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_ch    (branch_if),
    .out_ch   (pred_if)
  );

  // 10 ns clock.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // --------------------------------------------------------------------------
  // Shadow predictor state. It mirrors the tables of the block exactly and is
  // trained by every accepted branch word at the moment it is accepted.
  // --------------------------------------------------------------------------
  logic [BASE_W-1:0] bimodal_ctr [BE];
  logic [TB-1:0]     line_tag    [NT][TE];
  logic [PB-1:0]     line_ctr    [NT][TE];
  logic [USE_W-1:0]  line_useful [NT][TE];
  logic [HIST_W-1:0] ghist_lo;
  logic [HIST_W-1:0] ghist_hi;
  logic [DRAW_W-1:0] second_pick_pct;

  logic pending_pred [$];   // predictions still owed by the block
  int   errors;
  int   cycles;

  // Idling controls shared by the sender and the receiver.
  int tx_idle_pct;
  int rx_stall_pct;
  int hold_request;
  int hold_left;

  // Address pool for well-formed loop-like branch streams.
  logic [31:0] pool_addr   [POOL_SIZE];
  int          pool_period [POOL_SIZE];
  int          pool_count  [POOL_SIZE];

  function automatic void clear_shadow();
    for (int i = 0; i < BE; i++) bimodal_ctr[i] = BASE_RESET;
    for (int t = 0; t < NT; t++) begin
      for (int i = 0; i < TE; i++) begin
        line_tag[t][i]    = '0;
        line_ctr[t][i]    = '0;
        line_useful[t][i] = '0;
      end
    end
    ghist_lo        = '0;
    ghist_hi        = '0;
    second_pick_pct = SECOND_PICK_RESET;
  endfunction

  // Table t folds a history length from the geometric series, spread evenly
  // from the shortest to the longest entry.
  function automatic logic [63:0] fold_hash(logic [31:0] addr, int t);
    int len;
    logic [63:0] lo;
    logic [63:0] hi;
    len = HIST_LEN[t * (LEN_STEPS - 1) / (NT - 1)];
    if (len < 64) begin
      lo = ghist_lo & ((64'd1 << len) - 64'd1);
      hi = '0;
    end else if (len >= 128) begin
      lo = ghist_lo;
      hi = ghist_hi;
    end else begin
      lo = ghist_lo;
      hi = ghist_hi & ((64'd1 << (len - 64)) - 64'd1);
    end
    return lo ^ hi ^ {32'd0, addr};
  endfunction

  // Predicts one branch, then trains the shadow tables exactly as the block
  // does, and returns the prediction made before training.
  function automatic logic predict_and_train(logic [31:0] addr, logic taken,
                                             logic [DRAW_W-1:0] draw);
    int unsigned idx [NT];
    logic [TB-1:0] tagv [NT];
    logic [63:0] h;
    int bidx;
    int provider;
    int nfree;
    int first;
    int second;
    int pick;
    logic best;
    logic alt;
    bidx     = addr % BE;
    best     = bimodal_ctr[bidx] >= 2;
    alt      = 1'b0;
    provider = -1;
    for (int t = 0; t < NT; t++) begin
      h       = fold_hash(addr, t);
      idx[t]  = h % TE;
      tagv[t] = h[TB-1:0];
      if (line_tag[t][idx[t]] == tagv[t]) begin
        alt      = best;
        best     = line_ctr[t][idx[t]] >= CTR_HALF;
        provider = t;
      end
    end

    if (taken && bimodal_ctr[bidx] < 3) bimodal_ctr[bidx]++;
    else if (!taken && bimodal_ctr[bidx] > 0) bimodal_ctr[bidx]--;

    ghist_hi = {ghist_hi[62:0], ghist_lo[63]};
    ghist_lo = {ghist_lo[62:0], taken};

    if (provider >= 0) begin
      if (alt != best) begin
        if (best == taken && line_useful[provider][idx[provider]] < 3)
          line_useful[provider][idx[provider]]++;
        else if (best != taken && line_useful[provider][idx[provider]] > 0)
          line_useful[provider][idx[provider]]--;
      end
      if (taken && line_ctr[provider][idx[provider]] < CTR_MAX)
        line_ctr[provider][idx[provider]]++;
      else if (!taken && line_ctr[provider][idx[provider]] > 0)
        line_ctr[provider][idx[provider]]--;
    end

    // On a mispredict, allocate into a longer table with a clear useful
    // counter, or age every longer table when none is free.
    if (best != taken) begin
      nfree  = 0;
      first  = -1;
      second = -1;
      for (int t = provider + 1; t < NT; t++) begin
        if (line_useful[t][idx[t]] == 0) begin
          if (first < 0) first = t;
          else if (second < 0) second = t;
          nfree++;
        end
      end
      if (nfree > 0) begin
        pick = first;
        if (nfree > 1 && draw < second_pick_pct) pick = second;
        line_tag[pick][idx[pick]]    = tagv[pick];
        line_useful[pick][idx[pick]] = '0;
        line_ctr[pick][idx[pick]]    = taken ? PB'(CTR_HALF) : PB'(CTR_HALF - 1);
      end else begin
        for (int t = provider + 1; t < NT; t++)
          if (line_useful[t][idx[t]] > 0) line_useful[t][idx[t]]--;
      end
    end
    return best;
  endfunction

  // --------------------------------------------------------------------------
  // Sender. The word is offered until accepted; the shadow predictor runs at
  // the accepting edge so the expectation order matches the block's order.
  // Valid stays high between back-to-back words and only drops for a gap.
  // --------------------------------------------------------------------------
  task automatic send_branch(logic [31:0] addr, logic taken, logic [DRAW_W-1:0] draw);
    branch_if.valid          <= 1'b1;
    branch_if.branch_address <= addr;
    branch_if.outcome_taken  <= taken;
    branch_if.random_draw    <= draw;
    do @(posedge clk); while (!branch_if.ready);
    pending_pred.push_back(predict_and_train(addr, taken, draw));
    if ($urandom_range(99) < tx_idle_pct) begin
      branch_if.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
  endtask

  // Lowers valid, then waits until every owed prediction has returned and
  // the back end has had time to finish its write-back.
  task automatic wait_drained();
    branch_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_pred.size() != 0) @(posedge clk);
    repeat (DRAIN_GAP) @(posedge clk);
  endtask

  task automatic write_pick_pct(logic [DRAW_W-1:0] value);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    second_pick_pct = value;
    @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Receiver. Checks each accepted prediction word against the oldest owed
  // prediction, then picks the ready level for the next cycle. A long
  // hold-off request overrides the random stalling while it lasts.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && pred_if.valid && pred_if.ready) begin
      if (pending_pred.size() == 0) begin
        $display("%0t: unexpected prediction word: expected none, actual %0b",
                 $time, pred_if.predicted_taken);
        errors++;
      end else begin
        if (pred_if.predicted_taken !== pending_pred[0]) begin
          $display("%0t: predicted_taken mismatch: expected %0b, actual %0b",
                   $time, pending_pred[0], pred_if.predicted_taken);
          errors++;
        end
        void'(pending_pred.pop_front());
      end
    end
    if (hold_request > 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      pred_if.ready <= 1'b0;
    end else begin
      pred_if.ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // Watchdog: the slowest correct run stays far below this.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Right after reset every line holds tag zero, so an address whose low
  // bits fold to zero hits every table and the cleared counter says not
  // taken. A few follow-ups exercise the lines that this allocates.
  task automatic test_reset_tag_hits();
    send_branch(32'h0000_0000, 1'b0, 7'd0);
    send_branch(32'h0000_0800, 1'b1, 7'd10);
    send_branch(32'hFFFF_F800, 1'b1, 7'd50);
    send_branch(32'h0000_0000, 1'b1, 7'd99);
    send_branch(32'h0000_0000, 1'b0, 7'd127);
  endtask

  // Extremes of every field, both outcomes and repeated mispredicts on one
  // branch so that allocation walks up through the longer tables.
  task automatic test_field_extremes();
    send_branch(32'hFFFF_FFFF, 1'b1, 7'd0);
    send_branch(32'hFFFF_FFFF, 1'b0, 7'd127);
    send_branch(32'h8000_0000, 1'b1, 7'd99);
    send_branch(32'h0000_0001, 1'b0, 7'd100);
    send_branch(32'h5555_5555, 1'b1, 7'd32);
    send_branch(32'hAAAA_AAAA, 1'b0, 7'd33);
    for (int i = 0; i < 6; i++)
      send_branch(32'h0000_1234, i[0], 7'($urandom_range(0, 127)));
  endtask

  // Allocation choice under each extreme of the pick percentage: zero never
  // takes the second free table, one hundred and above nearly always does,
  // and out-of-range draws are compared as they are.
  task automatic test_pick_extremes();
    logic [DRAW_W-1:0] pct [4] = '{7'd0, 7'd100, 7'd127, 7'd1};
    for (int p = 0; p < 4; p++) begin
      write_pick_pct(pct[p]);
      for (int i = 0; i < 4; i++)
        send_branch(32'h0000_4000 + 32'(p * 16 + i), i[0], 7'(i * 42));
    end
  endtask

  task automatic refill_pool();
    for (int i = 0; i < POOL_SIZE; i++) begin
      pool_addr[i]   = $urandom();
      // Some branches fold to small hashes that collide with reset lines.
      if (i < 2) pool_addr[i][10:0] = '0;
      pool_period[i] = $urandom_range(2, 9);
      pool_count[i]  = 0;
    end
  endtask

  // Mostly loop-shaped branches from a small pool, so that history repeats
  // and the tagged tables hit, allocate and age; the rest is random noise.
  task automatic run_branch_stream(int count, int tx_pct, int rx_pct);
    int k;
    logic [31:0] addr;
    logic taken;
    logic [DRAW_W-1:0] draw;
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    refill_pool();
    for (int n = 0; n < count; n++) begin
      draw = ($urandom_range(9) == 0) ? 7'($urandom_range(0, 127))
                                      : 7'($urandom_range(0, 99));
      if ($urandom_range(99) < 15) begin
        addr  = $urandom();
        taken = $urandom_range(1);
      end else begin
        k     = $urandom_range(POOL_SIZE - 1);
        addr  = pool_addr[k];
        taken = (pool_count[k] % pool_period[k]) != pool_period[k] - 1;
        pool_count[k]++;
      end
      send_branch(addr, taken, draw);
      // Now and then let the pipeline run completely dry mid-stream.
      if ($urandom_range(199) == 0) wait_drained();
    end
    wait_drained();
  endtask

  // The receiver holds off for a long stretch while words keep coming, so
  // the output register and the queue fill and the input stalls.
  task automatic test_output_backpressure();
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    hold_request = 300;
    for (int i = 0; i < 40; i++)
      send_branch($urandom(), $urandom_range(1), 7'($urandom_range(0, 99)));
    wait_drained();
  endtask

  // --------------------------------------------------------------------------
  // Main sequence. Reset once, then directed tests, then random streams under
  // each idling mix with the pick percentage changed between phases.
  // --------------------------------------------------------------------------
  initial begin
    errors                   = 0;
    cycles                   = 0;
    tx_idle_pct              = 0;
    rx_stall_pct             = 0;
    hold_request             = 0;
    hold_left                = 0;
    rst_n                    = 1'b0;
    cfg_we                   = 1'b0;
    cfg_wdata                = '0;
    branch_if.valid          = 1'b0;
    branch_if.branch_address = '0;
    branch_if.outcome_taken  = 1'b0;
    branch_if.random_draw    = '0;
    pred_if.ready            = 1'b0;
    clear_shadow();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    // The block clears its tables after reset; input ready rises when done.
    do @(posedge clk); while (!branch_if.ready);

    test_reset_tag_hits();
    test_field_extremes();
    test_pick_extremes();
    test_output_backpressure();

    write_pick_pct(7'd33);
    run_branch_stream(450, 0, 0);
    write_pick_pct(7'd0);
    run_branch_stream(400, 70, 0);
    write_pick_pct(7'd100);
    run_branch_stream(400, 0, 70);
    write_pick_pct(7'd127);
    run_branch_stream(250, 18, 18);
    write_pick_pct(7'd50);
    run_branch_stream(250, 18, 18);

    test_output_backpressure();

    rx_stall_pct = 0;
    wait_drained();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
